FILE: rtl/core/owtavg_pkg.sv
package owtavg_pkg;

   // One scratchpad read as it arrives on the request channel.
   typedef struct packed {
      logic [7:0] temp_lsb;
      logic [7:0] temp_msb;
      logic [7:0] resolution_byte;
      logic [7:0] count_remain;
      logic [7:0] count_per_degree;
      logic       read_failed;
   } req_type;

   // One converted result as it leaves on the response channel.
   typedef struct packed {
      logic signed [15:0] sample_sixteenths;
      logic signed [15:0] average_sixteenths;
      logic               read_error;
   } rsp_type;

   // Push of one good sample into the history.
   typedef struct packed {
      logic               push;
      logic signed [15:0] sample;
   } hist_push_type;

   // Family code of the nine-bit part that reports count remain.
   localparam logic [7:0]  FAMILY_NINE_BIT   = 8'h10;
   // The refinement is only valid when the part reports 16 counts per degree.
   localparam logic [7:0]  COUNT_PER_DEG_STD = 8'h10;
   // Three-quarter degree bias of the count-remain refinement, in 1/16 degree.
   localparam logic [15:0] REFINE_BIAS       = 16'd12;
   localparam logic [15:0] WHOLE_DEG_MASK    = 16'hFFF0;

   // Resolution field, bits 6:5 of the configuration byte.
   localparam logic [1:0]  RES_9_BIT         = 2'b00;
   localparam logic [1:0]  RES_10_BIT        = 2'b01;
   localparam logic [1:0]  RES_11_BIT        = 2'b10;
   localparam logic [1:0]  RES_12_BIT        = 2'b11;

   // Toggling the top bit removes the +32768 bias carried in the mean.
   localparam logic [15:0] MEAN_BIAS_FLIP    = 16'h8000;

endpackage

FILE: rtl/core/onewire_temp_decode_average_top.sv
// Channel | Direction | Handshake         | Payload
// --------+-----------+-------------------+-------------------------------
// req     | in        | req_valid/stall   | owtavg_pkg::req_type scratchpad
// rsp     | out       | rsp_valid/stall   | owtavg_pkg::rsp_type result
// csr     | in        | csr_valid/ready   | 8-bit family code
//
// One request transaction is accepted per cycle unless req_stall is high; each
// gives one response transaction through the input, sum and quotient registers.
// Reset is synchronous and active high; it clears the family code, the history
// and the running sum at once, so the block accepts work in the next cycle.
// A stalled response holds the last stage, and bubbles in the earlier stages
// still fill, so the request side stalls only with all three stages occupied.
module onewire_temp_decode_average_top #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  owtavg_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owtavg_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);

   localparam int SUM_W = 16 + $clog2(HISTORY_DEPTH);

   // Configuration register. Writes must arrive only while the block is idle;
   // the block does not enforce this itself, and the port is always ready.
   logic [7:0] family_ff;
   logic [7:0] family_in;

   assign csr_ready = 1'b1;
   assign family_in = csr_valid ? csr_data : family_ff;

   // Stage A holds the accepted request transaction.
   logic                a_valid_ff;
   logic                a_valid_in;
   owtavg_pkg::req_type a_item_ff;
   owtavg_pkg::req_type a_item_in;

   // Stage B holds the decoded sample; the matching running sum lives in the
   // history, which is updated on the same edge the sample enters this stage.
   logic               b_valid_ff;
   logic               b_valid_in;
   logic signed [15:0] b_sample_ff;
   logic signed [15:0] b_sample_in;
   logic               b_error_ff;
   logic               b_error_in;

   // Stage C is the output register; the mean unit holds the quotient.
   logic               c_valid_ff;
   logic               c_valid_in;
   logic signed [15:0] c_sample_ff;
   logic signed [15:0] c_sample_in;
   logic               c_error_ff;
   logic               c_error_in;

   logic a_ready;
   logic b_ready;
   logic c_ready;
   logic b_load;
   logic c_load;

   logic signed [15:0]        dec_sample;
   owtavg_pkg::hist_push_type push_ctl;
   logic [SUM_W-1:0]          biased_sum;
   logic signed [15:0]        average;

   // Each stage can take a new transaction when it is empty or when its
   // content moves on in the same cycle.
   assign c_ready   = !c_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;

   assign a_valid_in = (req_valid && a_ready) || (a_valid_ff && !b_ready);
   assign a_item_in  = (req_valid && a_ready) ? req_data : a_item_ff;

   assign b_valid_in  = b_load || (b_valid_ff && !c_ready);
   assign b_sample_in = b_load ? dec_sample : b_sample_ff;
   assign b_error_in  = b_load ? a_item_ff.read_failed : b_error_ff;

   assign c_valid_in  = c_load || (c_valid_ff && rsp_stall);
   assign c_sample_in = c_load ? b_sample_ff : c_sample_ff;
   assign c_error_in  = c_load ? b_error_ff : c_error_ff;

   owtavg_decode u_decode (
      .item        (a_item_ff),
      .family_code (family_ff),
      .sample      (dec_sample)
   );

   // A failed read passes through the pipeline but leaves the history alone.
   assign push_ctl.push   = b_load && !a_item_ff.read_failed;
   assign push_ctl.sample = dec_sample;

   owtavg_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .push_ctl   (push_ctl),
      .biased_sum (biased_sum)
   );

   owtavg_mean #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_mean (
      .clock      (clock),
      .load       (c_load),
      .biased_sum (biased_sum),
      .average    (average)
   );

   always_ff @(posedge clock) begin
      a_item_ff   <= a_item_in;
      b_sample_ff <= b_sample_in;
      b_error_ff  <= b_error_in;
      c_sample_ff <= c_sample_in;
      c_error_ff  <= c_error_in;
      if (reset) begin
         family_ff  <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         family_ff  <= family_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // A failed read reports zeros in both value fields.
   assign rsp_valid                   = c_valid_ff;
   assign rsp_data.sample_sixteenths  = c_error_ff ? 16'sd0 : c_sample_ff;
   assign rsp_data.average_sixteenths = c_error_ff ? 16'sd0 : average;
   assign rsp_data.read_error         = c_error_ff;

   // The request side only stalls when every stage holds a transaction and the
   // response is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && c_valid_ff && rsp_stall))
      else $error("request stalled with a free pipeline stage");

   // A failed read moving into stage B must not touch the running sum.
   assert property (@(posedge clock) disable iff (reset)
      (b_load && a_item_ff.read_failed) |=> $stable(biased_sum))
      else $error("failed read changed the history sum");

   // A held response keeps its average while the history keeps moving.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data.average_sixteenths))
      else $error("stalled average changed");

   // Reset empties the output stage.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

FILE: rtl/core/owtavg_decode.sv
// Converts a raw scratchpad reading to a sample in 1/16 degree units.
module owtavg_decode (
   input  owtavg_pkg::req_type   item,
   input  logic [7:0]            family_code,
   output logic signed [15:0]    sample
);

   logic [15:0] raw;
   logic [15:0] shifted3;
   logic [15:0] refined;

   assign raw      = {item.temp_msb, item.temp_lsb};
   assign shifted3 = {raw[12:0], 3'b000};
   assign refined  = (shifted3 & owtavg_pkg::WHOLE_DEG_MASK) + owtavg_pkg::REFINE_BIAS
                     - {8'h00, item.count_remain};

   always_comb begin
      sample = signed'(raw);
      if (family_code == owtavg_pkg::FAMILY_NINE_BIT) begin
         if (item.count_per_degree == owtavg_pkg::COUNT_PER_DEG_STD) begin
            sample = signed'(refined);
         end else begin
            sample = signed'(shifted3);
         end
      end else begin
         case (item.resolution_byte[6:5])
            owtavg_pkg::RES_9_BIT:  sample = signed'(shifted3);
            owtavg_pkg::RES_10_BIT: sample = signed'({raw[13:0], 2'b00});
            owtavg_pkg::RES_11_BIT: sample = signed'({raw[14:0], 1'b0});
            owtavg_pkg::RES_12_BIT: sample = signed'(raw);
            default:                sample = signed'(raw);
         endcase
      end
   end

endmodule

FILE: rtl/core/owtavg_history.sv
// Sample history as a shift line plus a running sum. The sum carries a bias of
// 32768 per entry so that it is never negative.
module owtavg_history #(
   parameter  int HISTORY_DEPTH = 8,
   localparam int SUM_W         = 16 + $clog2(HISTORY_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  owtavg_pkg::hist_push_type  push_ctl,
   output logic [SUM_W-1:0]           biased_sum
);

   localparam logic [SUM_W-1:0] SUM_BIAS = SUM_W'(32'd32768 * HISTORY_DEPTH);

   logic [15:0]              hist_ff [HISTORY_DEPTH];
   logic [15:0]              hist_in [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [HISTORY_DEPTH-1:0] valid_in;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         sum_in;
   logic [15:0]              oldest;

   // Entries never written count as zero.
   assign oldest = valid_ff[HISTORY_DEPTH-1] ? hist_ff[HISTORY_DEPTH-1] : 16'h0000;

   always_comb begin
      hist_in  = hist_ff;
      valid_in = valid_ff;
      sum_in   = sum_ff;
      if (push_ctl.push) begin
         hist_in[0] = push_ctl.sample;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         valid_in = {valid_ff[HISTORY_DEPTH-2:0], 1'b1};
         sum_in   = sum_ff
                    + {{(SUM_W-16){push_ctl.sample[15]}}, push_ctl.sample}
                    - {{(SUM_W-16){oldest[15]}}, oldest};
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      if (reset) begin
         valid_ff <= '0;
         sum_ff   <= SUM_BIAS;
      end else begin
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
      end
   end

   assign biased_sum = sum_ff;

endmodule

FILE: rtl/core/owtavg_mean.sv
// Floor of the mean by multiplication with a rounded-up reciprocal. The input
// sum carries a bias of 32768 per entry, so it is unsigned and the quotient
// carries a bias of 32768, removed by toggling its top bit.
module owtavg_mean #(
   parameter  int HISTORY_DEPTH = 8,
   localparam int SUM_W         = 16 + $clog2(HISTORY_DEPTH)
) (
   input  logic               clock,
   input  logic               load,
   input  logic [SUM_W-1:0]   biased_sum,
   output logic signed [15:0] average
);

   localparam int         SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int         K_W   = SUM_W + 1;
   localparam int         P_W   = SUM_W + K_W;
   localparam logic [63:0] K_WIDE =
      ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
   localparam logic [K_W-1:0] RECIP = K_W'(K_WIDE);

   logic [P_W-1:0] product;
   logic [15:0]    quot_ff;
   logic [15:0]    quot_in;

   assign product = P_W'(biased_sum) * P_W'(RECIP);
   assign quot_in = load ? product[SHIFT+15:SHIFT] : quot_ff;

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign average = signed'(quot_ff ^ owtavg_pkg::MEAN_BIAS_FLIP);

endmodule
